>>> sv/dmlc_pkg.sv
// Shared types, codes and constants of the door motor, light and clock controller.
// Used by dmlc_cfg, dmlc_core and the top level; depends on nothing else.
package dmlc_pkg;

  // Fixed timing of the sequencer, in ticks.
  localparam logic [15:0] PULSE_TICKS   = 16'd100;
  localparam logic [15:0] PAUSE_TICKS   = 16'd1000;
  localparam logic [6:0]  CONFIRM_TICKS = 7'd100;
  localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

  // Item kinds carried in tuser.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_COMMAND = 2'd2;

  // User commands.
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_AUTO  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DAY_START   = 3'd0;
  localparam logic [2:0] REG_NIGHT_START = 3'd1;
  localparam logic [2:0] REG_MAX_CURRENT = 3'd2;
  localparam logic [2:0] REG_NIGHT_LUX   = 3'd3;
  localparam logic [2:0] REG_CONSISTENT  = 3'd4;
  localparam logic [2:0] REG_MAX_RUN     = 3'd5;
  localparam logic [2:0] REG_OBST_WINDOW = 3'd6;
  localparam logic [2:0] REG_MAX_TRIES   = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_OPEN_RUN     = 3'd1,
    PH_OPEN_PULSE   = 3'd2,
    PH_CLOSE_RUN    = 3'd3,
    PH_CLOSE_PULSE  = 3'd4,
    PH_GIVEUP_PULSE = 3'd5,
    PH_PAUSE        = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    DS_UNKNOWN = 3'd0,
    DS_OPENING = 3'd1,
    DS_OPENED  = 3'd2,
    DS_CLOSING = 3'd3,
    DS_CLOSED  = 3'd4
  } door_t;

  typedef enum logic [1:0] {
    DRV_OFF   = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } drive_t;

  typedef struct packed {
    logic [4:0]  day_start_hour;
    logic [4:0]  night_start_hour;
    logic [11:0] current_limit;
    logic [15:0] night_lux;
    logic [3:0]  consistent_readings;
    logic [15:0] max_run_ms;
    logic [15:0] obstruction_window_ms;
    logic [1:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [12:0] motor_current;
    logic [15:0]        lux;
    logic [4:0]         hour;
    logic [1:0]         command;
  } item_t;

  typedef struct packed {
    logic [1:0] attempts;
    logic       obstruction;
    logic       night;
    logic       automatic_res;
    door_t      door_state;
    drive_t     motor_drive;
  } res_t;

  // Status of the sequencer that the top level watches.
  typedef struct packed {
    phase_t     phase;
    logic       confirm_pending;
    logic [6:0] confirm_timer;
  } stat_t;

endpackage

>>> sv/door_motor_light_clock_controller_unit.sv
// Top level of the door motor, light and clock controller: stream ports, input and
// result registers. Depends on dmlc_pkg, dmlc_cfg and dmlc_core.
//
// This block sequences a motorised door. Every input word gives exactly one result
// word, in order. A word is taken into an input register, the sequencer state is
// updated from it by short logic once the output register is free, and the result
// lands in an output register, so a new word can be taken in every cycle, also
// while a finished result is still waiting to be taken. The input is held back
// only while a word waits in the input register behind a result that the output
// has not yet taken. Input words carry the item kind in tuser (0 millisecond tick
// with a motor current sample, 1 light and hour measurement, 2 user command). Reset
// starts an open run in automatic mode with the documented register defaults.
// Configuration writes may be made at any time the stream is quiet and are always
// accepted at once.
module door_motor_light_clock_controller_unit (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // motor_current[12:0], lux[28:13], hour[33:29],
                                     // command[35:34], zero fill above
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // motor_drive[1:0], door_state[4:2],
                                     // automatic_res[5], night[6], obstruction[7],
                                     // attempts[9:8], zero fill above
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dmlc_pkg::cfg_t  cfg;
  dmlc_pkg::item_t in_item;
  logic            in_valid;
  dmlc_pkg::res_t  res_comb;
  dmlc_pkg::res_t  out_res;
  logic            out_valid;
  logic            out_free;
  logic            fire;
  dmlc_pkg::stat_t stat;

  // The output register can take a new result when it is empty or being emptied.
  assign out_free      = !out_valid || m_axis_tready;
  // The held word is processed whenever its result has somewhere to go.
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  dmlc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmlc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (res_comb),
    .stat (stat)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.op            <= s_axis_tuser;
      in_item.motor_current <= signed'(s_axis_tdata[12:0]);
      in_item.lux           <= s_axis_tdata[28:13];
      in_item.hour          <= s_axis_tdata[33:29];
      in_item.command       <= s_axis_tdata[35:34];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_comb;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_res.attempts, out_res.obstruction, out_res.night,
                          out_res.automatic_res, out_res.door_state, out_res.motor_drive};

  // An overcurrent check can only be pending while the motor is on a run.
  assert property (@(posedge clk) disable iff (rst)
    stat.confirm_pending |-> (stat.phase == dmlc_pkg::PH_OPEN_RUN ||
                              stat.phase == dmlc_pkg::PH_CLOSE_RUN))
    else $error("overcurrent check pending outside a run");

  // The confirmation counter never reaches its terminal count while at rest.
  assert property (@(posedge clk) disable iff (rst)
    stat.confirm_timer < dmlc_pkg::CONFIRM_TICKS)
    else $error("confirmation counter overran");

  // A processed word always leaves a result waiting in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> m_axis_tvalid)
    else $error("processed word produced no result");

  // An obstruction is only seen during a close attempt, so attempts cannot be zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.obstruction) |-> (out_res.attempts != 2'd0))
    else $error("obstruction reported without a close attempt");

endmodule

>>> sv/dmlc_cfg.sv
// Configuration register file of the door controller.
// Depends on dmlc_pkg for the register indexes and the cfg_t bundle.
module dmlc_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output dmlc_pkg::cfg_t     cfg
);

  dmlc_pkg::cfg_t regs;

  // Writes are always taken; they land in the register the index selects.
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.day_start_hour        <= 5'd7;
      regs.night_start_hour      <= 5'd21;
      regs.current_limit         <= 12'd500;
      regs.night_lux             <= 16'd10;
      regs.consistent_readings   <= 4'd3;
      regs.max_run_ms            <= 16'd30000;
      regs.obstruction_window_ms <= 16'd5500;
      regs.max_tries             <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        dmlc_pkg::REG_DAY_START:   regs.day_start_hour        <= cfg_data[4:0];
        dmlc_pkg::REG_NIGHT_START: regs.night_start_hour      <= cfg_data[4:0];
        dmlc_pkg::REG_MAX_CURRENT: regs.current_limit         <= cfg_data[11:0];
        dmlc_pkg::REG_NIGHT_LUX:   regs.night_lux             <= cfg_data;
        dmlc_pkg::REG_CONSISTENT:  regs.consistent_readings   <= cfg_data[3:0];
        dmlc_pkg::REG_MAX_RUN:     regs.max_run_ms            <= cfg_data;
        dmlc_pkg::REG_OBST_WINDOW: regs.obstruction_window_ms <= cfg_data;
        dmlc_pkg::REG_MAX_TRIES:   regs.max_tries             <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/dmlc_core.sv
// Sequencer state and its single-pass update for one item of the door controller.
// Depends on dmlc_pkg; the result is registered by the top level.
module dmlc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  dmlc_pkg::item_t   item,
  input  dmlc_pkg::cfg_t    cfg,
  output dmlc_pkg::res_t    res,
  output dmlc_pkg::stat_t   stat
);

  dmlc_pkg::phase_t phase, phase_next;
  dmlc_pkg::door_t  door_status, door_status_next;
  logic [15:0] run_timer, run_timer_next;
  logic [6:0]  confirm_timer, confirm_timer_next;
  logic        confirm_pending, confirm_pending_next;
  logic [1:0]  close_tries, close_tries_next;
  logic        retry_pending, retry_pending_next;
  logic        auto_mode, auto_mode_next;
  logic        light_says_night, light_says_night_next;
  logic [3:0]  agree_count, agree_count_next;
  logic        night_verdict, night_verdict_next;
  logic        obstructed;

  always_comb begin
    logic [12:0] cur_u;
    logic [12:0] mag;
    logic        over;
    logic [15:0] rt;
    logic [6:0]  ct;
    logic        confirmed;
    logic        run_phase;
    logic        measured;
    logic        clock_night;
    logic [4:0]  n;

    phase_next            = phase;
    door_status_next      = door_status;
    run_timer_next        = run_timer;
    confirm_timer_next    = confirm_timer;
    confirm_pending_next  = confirm_pending;
    close_tries_next      = close_tries;
    retry_pending_next    = retry_pending;
    auto_mode_next        = auto_mode;
    light_says_night_next = light_says_night;
    agree_count_next      = agree_count;
    night_verdict_next    = night_verdict;
    obstructed            = 1'b0;

    // Magnitude of the signed sample; the most negative value stays 4096.
    cur_u     = unsigned'(item.motor_current);
    mag       = cur_u[12] ? (13'd0 - cur_u) : cur_u;
    over      = mag > {1'b0, cfg.current_limit};
    rt        = (run_timer == dmlc_pkg::TIMER_MAX) ? run_timer : run_timer + 16'd1;
    ct        = confirm_timer + 7'd1;
    confirmed = 1'b0;
    run_phase = (phase == dmlc_pkg::PH_OPEN_RUN) || (phase == dmlc_pkg::PH_CLOSE_RUN);
    measured  = item.lux < cfg.night_lux;
    clock_night = (item.hour >= cfg.night_start_hour) || (item.hour < cfg.day_start_hour);
    n         = {1'b0, agree_count} + 5'd1;

    case (item.op)
      dmlc_pkg::OP_TICK: begin
        run_timer_next = rt;
        if (run_phase) begin
          if (confirm_pending) begin
            if (ct >= dmlc_pkg::CONFIRM_TICKS) begin
              confirm_pending_next = 1'b0;
              confirm_timer_next   = 7'd0;
              confirmed            = over;
            end else begin
              confirm_timer_next = ct;
            end
          end else if (over) begin
            confirm_pending_next = 1'b1;
            confirm_timer_next   = 7'd0;
          end
          if (confirmed) begin
            if (phase == dmlc_pkg::PH_CLOSE_RUN && rt < cfg.obstruction_window_ms) begin
              obstructed = 1'b1;
              if (close_tries < cfg.max_tries) begin
                // Reopen straight away and retry after the pause.
                retry_pending_next = 1'b1;
                phase_next         = dmlc_pkg::PH_OPEN_RUN;
                door_status_next   = dmlc_pkg::DS_OPENING;
                run_timer_next     = 16'd0;
              end else begin
                phase_next     = dmlc_pkg::PH_GIVEUP_PULSE;
                run_timer_next = 16'd0;
              end
            end else begin
              run_timer_next = 16'd0;
              phase_next     = (phase == dmlc_pkg::PH_OPEN_RUN) ?
                               dmlc_pkg::PH_OPEN_PULSE : dmlc_pkg::PH_CLOSE_PULSE;
            end
          end else if (!confirm_pending_next && rt >= cfg.max_run_ms) begin
            confirm_pending_next = 1'b0;
            confirm_timer_next   = 7'd0;
            run_timer_next       = 16'd0;
            phase_next           = (phase == dmlc_pkg::PH_OPEN_RUN) ?
                                   dmlc_pkg::PH_OPEN_PULSE : dmlc_pkg::PH_CLOSE_PULSE;
          end
        end else if (phase == dmlc_pkg::PH_OPEN_PULSE) begin
          if (rt >= dmlc_pkg::PULSE_TICKS) begin
            door_status_next = dmlc_pkg::DS_OPENED;
            run_timer_next   = 16'd0;
            phase_next       = retry_pending ? dmlc_pkg::PH_PAUSE : dmlc_pkg::PH_IDLE;
          end
        end else if (phase == dmlc_pkg::PH_CLOSE_PULSE ||
                     phase == dmlc_pkg::PH_GIVEUP_PULSE) begin
          if (rt >= dmlc_pkg::PULSE_TICKS) begin
            door_status_next = (phase == dmlc_pkg::PH_CLOSE_PULSE) ?
                               dmlc_pkg::DS_CLOSED : dmlc_pkg::DS_UNKNOWN;
            run_timer_next   = 16'd0;
            phase_next       = dmlc_pkg::PH_IDLE;
          end
        end else if (phase == dmlc_pkg::PH_PAUSE) begin
          if (rt >= dmlc_pkg::PAUSE_TICKS) begin
            retry_pending_next   = 1'b0;
            phase_next           = dmlc_pkg::PH_CLOSE_RUN;
            door_status_next     = dmlc_pkg::DS_CLOSING;
            run_timer_next       = 16'd0;
            confirm_timer_next   = 7'd0;
            confirm_pending_next = 1'b0;
            close_tries_next     = close_tries + 2'd1;
          end
        end
      end

      dmlc_pkg::OP_MEASURE: begin
        if (auto_mode && phase == dmlc_pkg::PH_IDLE) begin
          if (measured != light_says_night) begin
            if (n > {1'b0, cfg.consistent_readings}) begin
              agree_count_next      = 4'd1;
              light_says_night_next = measured;
            end else begin
              agree_count_next = n[3:0];
            end
          end else begin
            agree_count_next = 4'd1;
          end
          night_verdict_next = clock_night || light_says_night_next;
          if (night_verdict_next && door_status == dmlc_pkg::DS_OPENED) begin
            phase_next           = dmlc_pkg::PH_CLOSE_RUN;
            door_status_next     = dmlc_pkg::DS_CLOSING;
            run_timer_next       = 16'd0;
            confirm_timer_next   = 7'd0;
            confirm_pending_next = 1'b0;
            close_tries_next     = 2'd1;
          end else if (!night_verdict_next && door_status == dmlc_pkg::DS_CLOSED) begin
            phase_next           = dmlc_pkg::PH_OPEN_RUN;
            door_status_next     = dmlc_pkg::DS_OPENING;
            run_timer_next       = 16'd0;
            confirm_timer_next   = 7'd0;
            confirm_pending_next = 1'b0;
          end
        end
      end

      dmlc_pkg::OP_COMMAND: begin
        case (item.command)
          dmlc_pkg::CMD_OPEN: begin
            if (phase == dmlc_pkg::PH_IDLE) begin
              auto_mode_next       = 1'b0;
              phase_next           = dmlc_pkg::PH_OPEN_RUN;
              door_status_next     = dmlc_pkg::DS_OPENING;
              run_timer_next       = 16'd0;
              confirm_timer_next   = 7'd0;
              confirm_pending_next = 1'b0;
            end
          end
          dmlc_pkg::CMD_CLOSE: begin
            if (phase == dmlc_pkg::PH_IDLE) begin
              auto_mode_next       = 1'b0;
              phase_next           = dmlc_pkg::PH_CLOSE_RUN;
              door_status_next     = dmlc_pkg::DS_CLOSING;
              run_timer_next       = 16'd0;
              confirm_timer_next   = 7'd0;
              confirm_pending_next = 1'b0;
              close_tries_next     = 2'd1;
            end
          end
          dmlc_pkg::CMD_STOP: begin
            auto_mode_next = 1'b0;
            if (run_phase) begin
              confirm_pending_next = 1'b0;
              confirm_timer_next   = 7'd0;
              run_timer_next       = 16'd0;
              phase_next           = (phase == dmlc_pkg::PH_OPEN_RUN) ?
                                     dmlc_pkg::PH_OPEN_PULSE : dmlc_pkg::PH_CLOSE_PULSE;
            end else if (phase == dmlc_pkg::PH_PAUSE) begin
              retry_pending_next = 1'b0;
              run_timer_next     = 16'd0;
              phase_next         = dmlc_pkg::PH_IDLE;
            end
          end
          default: begin
            auto_mode_next = 1'b1;
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dmlc_pkg::PH_OPEN_RUN;
      door_status      <= dmlc_pkg::DS_OPENING;
      run_timer        <= 16'd0;
      confirm_timer    <= 7'd0;
      confirm_pending  <= 1'b0;
      close_tries      <= 2'd0;
      retry_pending    <= 1'b0;
      auto_mode        <= 1'b1;
      light_says_night <= 1'b0;
      agree_count      <= 4'd0;
      night_verdict    <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      door_status      <= door_status_next;
      run_timer        <= run_timer_next;
      confirm_timer    <= confirm_timer_next;
      confirm_pending  <= confirm_pending_next;
      close_tries      <= close_tries_next;
      retry_pending    <= retry_pending_next;
      auto_mode        <= auto_mode_next;
      light_says_night <= light_says_night_next;
      agree_count      <= agree_count_next;
      night_verdict    <= night_verdict_next;
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    case (phase_next)
      dmlc_pkg::PH_OPEN_RUN,
      dmlc_pkg::PH_CLOSE_PULSE,
      dmlc_pkg::PH_GIVEUP_PULSE: res.motor_drive = dmlc_pkg::DRV_OPEN;
      dmlc_pkg::PH_OPEN_PULSE,
      dmlc_pkg::PH_CLOSE_RUN:    res.motor_drive = dmlc_pkg::DRV_CLOSE;
      default:                   res.motor_drive = dmlc_pkg::DRV_OFF;
    endcase
    res.door_state    = door_status_next;
    res.automatic_res = auto_mode_next;
    res.night         = night_verdict_next;
    res.obstruction   = obstructed;
    res.attempts      = close_tries_next;
  end

  assign stat.phase           = phase;
  assign stat.confirm_pending = confirm_pending;
  assign stat.confirm_timer   = confirm_timer;

endmodule

>>> verif/door_motor_light_clock_controller_unit_checker.sv
`timescale 1ns / 1ps
// Result checker for the door motor, light and clock controller: watches the three
// channels, predicts every result word and compares it. Depends on dmlc_pkg.
module door_motor_light_clock_controller_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // motor_current[12:0], lux[28:13], hour[33:29],
                                     // command[35:34], zero fill above
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // motor_drive[1:0], door_state[4:2],
                                     // automatic_res[5], night[6], obstruction[7],
                                     // attempts[9:8], zero fill above
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          results_due
);

  dmlc_pkg::cfg_t   regs;
  dmlc_pkg::phase_t ph;
  dmlc_pkg::door_t  door;
  logic [15:0] run_ticks;
  logic [6:0]  confirm_ticks;
  logic        confirm_wait;
  logic        retry_wait;
  logic        auto_on;
  logic        light_night;
  logic        night_now;
  logic [1:0]  close_count;
  logic [3:0]  flip_votes;

  dmlc_pkg::res_t due_results[$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  function automatic void start_open();
    ph            = dmlc_pkg::PH_OPEN_RUN;
    door          = dmlc_pkg::DS_OPENING;
    run_ticks     = '0;
    confirm_ticks = '0;
    confirm_wait  = 1'b0;
  endfunction

  function automatic void start_close();
    ph            = dmlc_pkg::PH_CLOSE_RUN;
    door          = dmlc_pkg::DS_CLOSING;
    run_ticks     = '0;
    confirm_ticks = '0;
    confirm_wait  = 1'b0;
    close_count   = close_count + 2'd1;
  endfunction

  function automatic void finish_run();
    confirm_wait  = 1'b0;
    confirm_ticks = '0;
    run_ticks     = '0;
    ph = (ph == dmlc_pkg::PH_OPEN_RUN) ? dmlc_pkg::PH_OPEN_PULSE : dmlc_pkg::PH_CLOSE_PULSE;
  endfunction

  // One millisecond tick; returns 1 when it detects an obstruction.
  function automatic logic apply_tick(logic [12:0] sample);
    logic [13:0] mag;
    logic        over;
    logic        confirmed;
    logic        blocked;
    mag       = sample[12] ? (14'h2000 - {1'b0, sample}) : {1'b0, sample};
    over      = mag > {2'b00, regs.current_limit};
    confirmed = 1'b0;
    blocked   = 1'b0;
    if (run_ticks != dmlc_pkg::TIMER_MAX) run_ticks = run_ticks + 16'd1;
    case (ph)
      dmlc_pkg::PH_OPEN_RUN, dmlc_pkg::PH_CLOSE_RUN: begin
        if (confirm_wait) begin
          confirm_ticks = confirm_ticks + 7'd1;
          if (confirm_ticks >= dmlc_pkg::CONFIRM_TICKS) begin
            confirm_wait  = 1'b0;
            confirm_ticks = '0;
            confirmed     = over;
          end
        end else if (over) begin
          confirm_wait  = 1'b1;
          confirm_ticks = '0;
        end
        if (confirmed) begin
          if (ph == dmlc_pkg::PH_CLOSE_RUN && run_ticks < regs.obstruction_window_ms) begin
            blocked = 1'b1;
            if (close_count < regs.max_tries) begin
              retry_wait = 1'b1;
              start_open();
            end else begin
              ph        = dmlc_pkg::PH_GIVEUP_PULSE;
              run_ticks = '0;
            end
          end else begin
            finish_run();
          end
        end else if (!confirm_wait && run_ticks >= regs.max_run_ms) begin
          finish_run();
        end
      end
      dmlc_pkg::PH_OPEN_PULSE: begin
        if (run_ticks >= dmlc_pkg::PULSE_TICKS) begin
          door      = dmlc_pkg::DS_OPENED;
          run_ticks = '0;
          ph        = retry_wait ? dmlc_pkg::PH_PAUSE : dmlc_pkg::PH_IDLE;
        end
      end
      dmlc_pkg::PH_CLOSE_PULSE, dmlc_pkg::PH_GIVEUP_PULSE: begin
        if (run_ticks >= dmlc_pkg::PULSE_TICKS) begin
          door      = (ph == dmlc_pkg::PH_CLOSE_PULSE) ?
                      dmlc_pkg::DS_CLOSED : dmlc_pkg::DS_UNKNOWN;
          run_ticks = '0;
          ph        = dmlc_pkg::PH_IDLE;
        end
      end
      dmlc_pkg::PH_PAUSE: begin
        if (run_ticks >= dmlc_pkg::PAUSE_TICKS) begin
          retry_wait = 1'b0;
          start_close();
        end
      end
      default: ;
    endcase
    return blocked;
  endfunction

  function automatic void apply_measure(logic [15:0] lux, logic [4:0] hour);
    logic       dark;
    logic       clock_dark;
    logic [4:0] votes;
    if (!auto_on || ph != dmlc_pkg::PH_IDLE) return;
    dark = lux < regs.night_lux;
    if (dark != light_night) begin
      votes = {1'b0, flip_votes} + 5'd1;
      if (votes > {1'b0, regs.consistent_readings}) begin
        flip_votes  = 4'd1;
        light_night = dark;
      end else begin
        flip_votes = votes[3:0];
      end
    end else begin
      flip_votes = 4'd1;
    end
    clock_dark = (hour >= regs.night_start_hour) || (hour < regs.day_start_hour);
    night_now  = clock_dark || light_night;
    if (night_now && door == dmlc_pkg::DS_OPENED) begin
      close_count = 2'd0;
      start_close();
    end else if (!night_now && door == dmlc_pkg::DS_CLOSED) begin
      start_open();
    end
  endfunction

  function automatic void apply_command(logic [1:0] cmd);
    case (cmd)
      dmlc_pkg::CMD_OPEN: begin
        if (ph == dmlc_pkg::PH_IDLE) begin
          auto_on = 1'b0;
          start_open();
        end
      end
      dmlc_pkg::CMD_CLOSE: begin
        if (ph == dmlc_pkg::PH_IDLE) begin
          auto_on     = 1'b0;
          close_count = 2'd0;
          start_close();
        end
      end
      dmlc_pkg::CMD_STOP: begin
        auto_on = 1'b0;
        if (ph == dmlc_pkg::PH_OPEN_RUN || ph == dmlc_pkg::PH_CLOSE_RUN) begin
          finish_run();
        end else if (ph == dmlc_pkg::PH_PAUSE) begin
          retry_wait = 1'b0;
          run_ticks  = '0;
          ph         = dmlc_pkg::PH_IDLE;
        end
      end
      default: auto_on = 1'b1;
    endcase
  endfunction

  // Advances the prediction by one input word and returns the status it leaves.
  function automatic dmlc_pkg::res_t door_result_after(logic [1:0] op, logic [39:0] data);
    dmlc_pkg::res_t r;
    logic blocked;
    blocked = 1'b0;
    case (op)
      dmlc_pkg::OP_TICK:    blocked = apply_tick(data[12:0]);
      dmlc_pkg::OP_MEASURE: apply_measure(data[28:13], data[33:29]);
      dmlc_pkg::OP_COMMAND: apply_command(data[35:34]);
      default: ;
    endcase
    case (ph)
      dmlc_pkg::PH_OPEN_RUN, dmlc_pkg::PH_CLOSE_PULSE,
      dmlc_pkg::PH_GIVEUP_PULSE:                   r.motor_drive = dmlc_pkg::DRV_OPEN;
      dmlc_pkg::PH_OPEN_PULSE, dmlc_pkg::PH_CLOSE_RUN: r.motor_drive = dmlc_pkg::DRV_CLOSE;
      default:                                     r.motor_drive = dmlc_pkg::DRV_OFF;
    endcase
    r.door_state    = door;
    r.automatic_res = auto_on;
    r.night         = night_now;
    r.obstruction   = blocked;
    r.attempts      = close_count;
    return r;
  endfunction

  function automatic void reset_prediction();
    regs.day_start_hour        = 5'd7;
    regs.night_start_hour      = 5'd21;
    regs.current_limit         = 12'd500;
    regs.night_lux             = 16'd10;
    regs.consistent_readings   = 4'd3;
    regs.max_run_ms            = 16'd30000;
    regs.obstruction_window_ms = 16'd5500;
    regs.max_tries             = 2'd3;
    ph            = dmlc_pkg::PH_OPEN_RUN;
    door          = dmlc_pkg::DS_OPENING;
    run_ticks     = '0;
    confirm_ticks = '0;
    confirm_wait  = 1'b0;
    close_count   = 2'd0;
    retry_wait    = 1'b0;
    auto_on       = 1'b1;
    light_night   = 1'b0;
    flip_votes    = 4'd0;
    night_now     = 1'b0;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [15:0] value);
    case (idx)
      dmlc_pkg::REG_DAY_START:   regs.day_start_hour        = value[4:0];
      dmlc_pkg::REG_NIGHT_START: regs.night_start_hour      = value[4:0];
      dmlc_pkg::REG_MAX_CURRENT: regs.current_limit         = value[11:0];
      dmlc_pkg::REG_NIGHT_LUX:   regs.night_lux             = value;
      dmlc_pkg::REG_CONSISTENT:  regs.consistent_readings   = value[3:0];
      dmlc_pkg::REG_MAX_RUN:     regs.max_run_ms            = value;
      dmlc_pkg::REG_OBST_WINDOW: regs.obstruction_window_ms = value;
      dmlc_pkg::REG_MAX_TRIES:   regs.max_tries             = value[1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    dmlc_pkg::res_t want;
    dmlc_pkg::res_t got;
    if (rst) begin
      reset_prediction();
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(door_result_after(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result word 0x%04h arrived with no expectation waiting", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          got  = dmlc_pkg::res_t'(m_axis_tdata[9:0]);
          check_field("motor_drive", want.motor_drive, got.motor_drive);
          check_field("door_state", want.door_state, got.door_state);
          check_field("automatic_res", want.automatic_res, got.automatic_res);
          check_field("night", want.night, got.night);
          check_field("obstruction", want.obstruction, got.obstruction);
          check_field("attempts", want.attempts, got.attempts);
          check_field("zero fill", 0, m_axis_tdata[15:10]);
        end
      end
    end
    results_due = due_results.size();
  end

endmodule

>>> verif/door_motor_light_clock_controller_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the door motor, light and clock controller: clock, reset, word
// and register stimulus, and the verdict. Depends on dmlc_pkg and the result checker.
module door_motor_light_clock_controller_unit_tb;

  // Item kind outside the defined set; the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatch_count;
  int results_due;

  // Sender and receiver behaviour, changed between phases of the run.
  int             idle_pct;
  logic           steady;
  logic           hold_req;
  int             surge_left;
  dmlc_pkg::cfg_t setting;

  door_motor_light_clock_controller_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  door_motor_light_clock_controller_unit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net: the slowest correct run is a small fraction of this.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver. It stalls in about one cycle in five, never stalls while the steady
  // stretch is on, and once, when the sender asks for it, holds off for a long
  // stretch that it counts itself, so that the output register fills and the block
  // pushes back on its input.
  initial begin
    int   hold_left;
    logic held;
    hold_left     = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  function automatic logic [39:0] pack_word(logic [12:0] cur, logic [15:0] lux,
                                            logic [4:0] hour, logic [1:0] cmd);
    return {4'b0000, cmd, hour, lux, cur};
  endfunction

  // Offers one word. It is called just after a falling edge and returns just after
  // the falling edge that follows acceptance, with tvalid still high.
  task automatic offer_word(logic [1:0] op, logic [39:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result word has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all eight registers back to back, only while the stream is quiet.
  task automatic load_setting(dmlc_pkg::cfg_t c);
    write_reg(dmlc_pkg::REG_DAY_START, {11'd0, c.day_start_hour});
    write_reg(dmlc_pkg::REG_NIGHT_START, {11'd0, c.night_start_hour});
    write_reg(dmlc_pkg::REG_MAX_CURRENT, {4'd0, c.current_limit});
    write_reg(dmlc_pkg::REG_NIGHT_LUX, c.night_lux);
    write_reg(dmlc_pkg::REG_CONSISTENT, {12'd0, c.consistent_readings});
    write_reg(dmlc_pkg::REG_MAX_RUN, c.max_run_ms);
    write_reg(dmlc_pkg::REG_OBST_WINDOW, c.obstruction_window_ms);
    write_reg(dmlc_pkg::REG_MAX_TRIES, {14'd0, c.max_tries});
    cfg_valid <= 1'b0;
    setting = c;
  endtask

  // Motor current sample. Mostly below the limit, but now and then a surge stays
  // above it long enough for the overcurrent to be confirmed, which ends runs and
  // causes obstructions early in close runs. A tenth of quiet samples are fully
  // random so that every bit of the field is exercised.
  function automatic logic [12:0] next_current(int surge_pct);
    int          lim;
    int          mag;
    logic [12:0] v;
    lim = setting.current_limit;
    if (surge_left == 0 && $urandom_range(99) < surge_pct)
      surge_left = $urandom_range(250, 80);
    if (surge_left > 0) begin
      surge_left--;
      if (lim >= 4095) begin
        v = 13'h1000;
      end else begin
        mag = $urandom_range(4096, lim + 1);
        v = 13'((mag == 4096 || $urandom_range(1) == 1) ? 8192 - mag : mag);
      end
    end else if ($urandom_range(99) < 10) begin
      v = 13'($urandom_range(8191));
    end else begin
      mag = $urandom_range(lim, 0);
      v = 13'(($urandom_range(1) == 1) ? 8192 - mag : mag);
    end
    return v;
  endfunction

  // One random word: ticks dominate so that runs, pulses and pauses play out; light
  // readings sit on either side of the threshold to drive the debounce; commands
  // lean towards restoring automatic mode so that night closing keeps happening.
  task automatic offer_random_word(int surge_pct);
    int          pick;
    int          cmd_pick;
    logic [15:0] lux;
    logic [1:0]  cmd;
    pick = $urandom_range(99);
    if (pick < 74) begin
      offer_word(dmlc_pkg::OP_TICK,
                 pack_word(next_current(surge_pct), 16'($urandom), 5'($urandom), 2'd0));
    end else if (pick < 88) begin
      if ($urandom_range(99) < 30)
        lux = 16'($urandom_range(65535));
      else if (setting.night_lux != 0 && $urandom_range(1) == 1)
        lux = 16'($urandom_range(setting.night_lux - 1, 0));
      else
        lux = 16'($urandom_range(65535, setting.night_lux));
      offer_word(dmlc_pkg::OP_MEASURE,
                 pack_word(13'd0, lux, 5'($urandom_range(23)), 2'd0));
    end else if (pick < 98) begin
      cmd_pick = $urandom_range(99);
      if (cmd_pick < 35)      cmd = dmlc_pkg::CMD_AUTO;
      else if (cmd_pick < 60) cmd = dmlc_pkg::CMD_STOP;
      else if (cmd_pick < 80) cmd = dmlc_pkg::CMD_OPEN;
      else                    cmd = dmlc_pkg::CMD_CLOSE;
      offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, cmd));
    end else begin
      offer_word(OP_UNUSED, pack_word(13'($urandom), 16'($urandom), 5'($urandom),
                                      2'($urandom)));
    end
  endtask

  initial begin
    dmlc_pkg::cfg_t plan[8];
    int             counts[8];
    int             surge[8];
    int             p;
    int             n;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dmlc_pkg::OP_TICK;
    cfg_valid     = 1'b0;
    cfg_index     = dmlc_pkg::REG_DAY_START;
    cfg_data      = '0;
    idle_pct      = 20;
    steady        = 1'b0;
    hold_req      = 1'b0;
    surge_left    = 0;
    setting       = '{5'd7, 5'd21, 12'd500, 16'd10, 4'd3, 16'd30000, 16'd5500, 2'd3};

    // Settings of the phases: a moderate one, the low extremes, a moderate one with
    // two tries, a long one built for repeated obstructions and retries, the high
    // extremes, the zero cases (run limit, tries and debounce count all zero), and
    // two random ones.
    plan[0] = '{5'd7, 5'd21, 12'd500, 16'd10, 4'd3, 16'd200, 16'd500, 2'd3};
    plan[1] = '{5'd0, 5'd0, 12'd0, 16'd0, 4'd1, 16'd1, 16'd0, 2'd1};
    plan[2] = '{5'd8, 5'd18, 12'd800, 16'd200, 4'd2, 16'd150, 16'd400, 2'd2};
    plan[3] = '{5'd6, 5'd19, 12'd400, 16'd300, 4'd2, 16'd250, 16'd600, 2'd3};
    plan[4] = '{5'd23, 5'd23, 12'd4095, 16'd65535, 4'd15, 16'd65535, 16'd65535, 2'd3};
    plan[5] = '{5'd6, 5'd20, 12'd300, 16'd1000, 4'd0, 16'd0, 16'd300, 2'd0};
    for (p = 6; p < 8; p++) begin
      plan[p].day_start_hour        = 5'($urandom_range(23));
      plan[p].night_start_hour      = 5'($urandom_range(23));
      plan[p].current_limit         = 12'($urandom_range(4095));
      plan[p].night_lux             = 16'($urandom_range(2000));
      plan[p].consistent_readings   = 4'($urandom_range(15, 1));
      plan[p].max_run_ms            = 16'($urandom_range(400, 1));
      plan[p].obstruction_window_ms = 16'($urandom_range(700));
      plan[p].max_tries             = 2'($urandom_range(3, 1));
    end
    for (p = 0; p < 8; p++) begin
      counts[p] = 150;
      surge[p]  = 3;
    end
    counts[3] = 1100;
    surge[3]  = 8;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset settings, while the open run started by reset
    // is still going: current extremes, measurements and open or close commands that
    // must be ignored while busy, the unused item kind, a stop that ends the run and
    // enters manual mode, a stop during the pulse, and a current right at the limit.
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'd0, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'h1000, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'h0FFF, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'h1FFF, 16'hFFFF, 5'd31, 2'd3));
    offer_word(dmlc_pkg::OP_MEASURE, pack_word(13'd0, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_MEASURE, pack_word(13'd0, 16'hFFFF, 5'd23, 2'd0));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_OPEN));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_CLOSE));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_AUTO));
    offer_word(OP_UNUSED, pack_word(13'h1FFF, 16'hFFFF, 5'd31, 2'd3));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_STOP));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_STOP));
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'd500, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_TICK, pack_word(13'h1E0B, 16'd0, 5'd0, 2'd0));
    offer_word(dmlc_pkg::OP_MEASURE, pack_word(13'd0, 16'd5, 5'd22, 2'd0));
    offer_word(dmlc_pkg::OP_COMMAND, pack_word(13'd0, 16'd0, 5'd0, dmlc_pkg::CMD_AUTO));

    for (p = 0; p < 8; p++) begin
      // Registers change only once every expected result word has come back.
      drain_results();
      load_setting(plan[p]);
      idle_pct <= (p == 2) ? 0 : 20;
      steady   <= (p == 2);
      if (p == 3) hold_req <= 1'b1;
      @(negedge clk);
      for (n = 0; n < counts[p]; n++) offer_random_word(surge[p]);
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
